@@ rtl/core/perspective_point_projection_defines.svh @@
// assertion macros for the perspective point projection block
// used by files that hold concurrent checks; expects clk_i and rst_ni in scope
`ifndef PERSPECTIVE_POINT_PROJECTION_DEFINES_SVH
`define PERSPECTIVE_POINT_PROJECTION_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define PPP_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("same-cycle check failed");
`define PPP_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define PPP_ASSERT_IMPL(name, ante, cons)
`define PPP_ASSERT_NEXT(name, ante, cons)
`endif

`endif

@@ rtl/core/ppp_pkg.sv @@
// shared types, widths and register codes of the point projection block
// no dependencies
package ppp_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int COORD_W    = 32;
  localparam int PROD_W     = 2 * COORD_W;
  localparam int SHP_W      = PROD_W - FRAC_BITS;
  localparam int DOT_W      = SHP_W + 2;
  localparam int NDC_LOG    = 40;
  localparam int Q_W        = NDC_LOG;
  localparam int NDC_W      = Q_W + 2;
  localparam int DISP_W     = 15;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 64;

  localparam int THR_RAW = ((1 << FRAC_BITS) + 500) / 1000;
  localparam int THRESH  = (THR_RAW < 1) ? 1 : THR_RAW;

  localparam int DOT_LAT  = 3;
  localparam int DIV_LAT  = Q_W + 2;
  localparam int MAP_LAT  = 2;
  localparam int PIPE_LAT = DOT_LAT + DIV_LAT + MAP_LAT;

  localparam logic [DISP_W-1:0] WIDTH_RST  = DISP_W'(1920);
  localparam logic [DISP_W-1:0] HEIGHT_RST = DISP_W'(1080);

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [DOT_W-1:0]   dot_t;
  typedef logic signed [NDC_W-1:0]   ndc_t;
  typedef logic [DISP_W-1:0]         disp_t;

  typedef struct packed {
    coord_t e0;
    coord_t e1;
    coord_t e2;
    coord_t e3;
  } mat_row_t;

  typedef struct packed {
    mat_row_t r0;
    mat_row_t r1;
    mat_row_t r3;
  } mat_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROW0_A = 4'd0,
    CFG_ROW0_B = 4'd1,
    CFG_ROW1_A = 4'd2,
    CFG_ROW1_B = 4'd3,
    CFG_ROW3_A = 4'd4,
    CFG_ROW3_B = 4'd5,
    CFG_WIDTH  = 4'd6,
    CFG_HEIGHT = 4'd7
  } cfg_idx_e;

endpackage

@@ rtl/core/ppp_dot.sv @@
// three-stage dot products of the point with matrix rows 0, 1 and 3, plus a visibility flag on w
// depends on ppp_pkg
module ppp_dot (
  input  logic            clk_i,
  input  logic            en_i,
  input  ppp_pkg::coord_t point_x_i,
  input  ppp_pkg::coord_t point_y_i,
  input  ppp_pkg::coord_t point_z_i,
  input  ppp_pkg::mat_t   mat_i,
  output ppp_pkg::dot_t   cx_o,
  output ppp_pkg::dot_t   cy_o,
  output ppp_pkg::dot_t   w_o,
  output logic            vis_o
);
  import ppp_pkg::*;

  localparam int NR = 3;

  mat_row_t                 rows [NR];
  coord_t                   pt [3];
  logic signed [PROD_W-1:0] prod_q [NR][3];
  logic signed [SHP_W-1:0]  shp [NR][3];
  logic signed [SHP_W:0]    pair_q [NR];
  logic signed [SHP_W:0]    rest_q [NR];
  dot_t                     dot_q [NR];

  assign rows[0] = mat_i.r0;
  assign rows[1] = mat_i.r1;
  assign rows[2] = mat_i.r3;
  assign pt[0]   = point_x_i;
  assign pt[1]   = point_y_i;
  assign pt[2]   = point_z_i;

  // floor shift of each exact product
  always_comb begin
    for (int r = 0; r < NR; r++) begin
      for (int k = 0; k < 3; k++) begin
        shp[r][k] = SHP_W'(prod_q[r][k] >>> FRAC_BITS);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int r = 0; r < NR; r++) begin
        prod_q[r][0] <= rows[r].e0 * pt[0];
        prod_q[r][1] <= rows[r].e1 * pt[1];
        prod_q[r][2] <= rows[r].e2 * pt[2];
        pair_q[r]    <= (SHP_W+1)'(shp[r][0]) + (SHP_W+1)'(shp[r][1]);
        rest_q[r]    <= (SHP_W+1)'(shp[r][2]) + (SHP_W+1)'(rows[r].e3);
        dot_q[r]     <= DOT_W'(pair_q[r]) + DOT_W'(rest_q[r]);
      end
    end
  end

  assign cx_o  = dot_q[0];
  assign cy_o  = dot_q[1];
  assign w_o   = dot_q[2];
  assign vis_o = (dot_q[2] >= dot_t'(THRESH));

endmodule

@@ rtl/core/ppp_div.sv @@
// pipelined restoring divider, two dividends over one shared divisor
// one quotient bit per stage, saturated magnitude; depends on ppp_pkg
module ppp_div (
  input  logic          clk_i,
  input  logic          en_i,
  input  ppp_pkg::dot_t c0_i,
  input  ppp_pkg::dot_t c1_i,
  input  ppp_pkg::dot_t w_i,
  output ppp_pkg::ndc_t q0_o,
  output ppp_pkg::ndc_t q1_o
);
  import ppp_pkg::*;

  localparam int NL  = 2;
  localparam int N_W = DOT_W + FRAC_BITS;
  localparam logic [Q_W:0] Q_LIMIT = {1'b1, {Q_W{1'b0}}};

  dot_t             cin [NL];
  logic [DOT_W-1:0] mag [NL];
  logic [N_W-1:0]   num [NL];
  logic [DOT_W-1:0] rinit [NL];
  logic [DOT_W-1:0] wu;

  logic [DOT_W-1:0] rem_q [NL][0:Q_W-1];
  logic [Q_W-1:0]   nq_q  [NL][0:Q_W];
  logic             neg_q [NL][0:Q_W];
  logic             sat_q [NL][0:Q_W];
  logic [DOT_W-1:0] wd_q  [0:Q_W-1];

  logic [DOT_W:0]   trial [NL][1:Q_W];
  logic             ge    [NL][1:Q_W];
  logic [Q_W:0]     qm    [NL];
  ndc_t             ndc_q [NL];

  assign cin[0] = c0_i;
  assign cin[1] = c1_i;
  assign wu     = DOT_W'(w_i);

  always_comb begin
    for (int l = 0; l < NL; l++) begin
      mag[l]   = cin[l][DOT_W-1] ? DOT_W'(-cin[l]) : DOT_W'(cin[l]);
      num[l]   = {mag[l], {FRAC_BITS{1'b0}}};
      rinit[l] = DOT_W'(num[l] >> Q_W);
      for (int s = 1; s <= Q_W; s++) begin
        trial[l][s] = {rem_q[l][s-1], nq_q[l][s-1][Q_W-1]};
        ge[l][s]    = (trial[l][s] >= {1'b0, wd_q[s-1]});
      end
      qm[l] = sat_q[l][Q_W] ? Q_LIMIT : {1'b0, nq_q[l][Q_W]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      wd_q[0] <= wu;
      for (int s = 1; s < Q_W; s++) begin
        wd_q[s] <= wd_q[s-1];
      end
      for (int l = 0; l < NL; l++) begin
        rem_q[l][0] <= rinit[l];
        nq_q[l][0]  <= num[l][Q_W-1:0];
        neg_q[l][0] <= cin[l][DOT_W-1];
        sat_q[l][0] <= (rinit[l] >= wu);
        for (int s = 1; s <= Q_W; s++) begin
          if (s < Q_W) begin
            rem_q[l][s] <= ge[l][s] ? DOT_W'(trial[l][s] - {1'b0, wd_q[s-1]})
                                    : DOT_W'(trial[l][s]);
          end
          nq_q[l][s]  <= {nq_q[l][s-1][Q_W-2:0], ge[l][s]};
          neg_q[l][s] <= neg_q[l][s-1];
          sat_q[l][s] <= sat_q[l][s-1];
        end
        ndc_q[l] <= neg_q[l][Q_W] ? -ndc_t'(qm[l]) : ndc_t'(qm[l]);
      end
    end
  end

  assign q0_o = ndc_q[0];
  assign q1_o = ndc_q[1];

endmodule

@@ rtl/core/ppp_map.sv @@
// pixel mapping of one axis: scale by display size, offset, saturate, zero when not visible
// two stages, output register last; depends on ppp_pkg
module ppp_map (
  input  logic           clk_i,
  input  logic           en_i,
  input  logic           vis_i,
  input  logic           sub_i,
  input  ppp_pkg::disp_t disp_i,
  input  ppp_pkg::ndc_t  ndc_i,
  output ppp_pkg::coord_t coord_o
);
  import ppp_pkg::*;

  localparam int T_W = NDC_W + DISP_W + 1;
  localparam int S_W = T_W + 1;
  localparam logic signed [S_W-1:0] SAT_HI = {{(S_W-COORD_W+1){1'b0}}, {(COORD_W-1){1'b1}}};
  localparam logic signed [S_W-1:0] SAT_LO = {{(S_W-COORD_W+1){1'b1}}, {(COORD_W-1){1'b0}}};

  logic signed [T_W-1:0] t_q;
  logic signed [T_W-1:0] half;
  logic signed [S_W-1:0] base;
  logic signed [S_W-1:0] sum;
  coord_t                res_d;
  coord_t                res_q;

  always_comb begin
    half = t_q >>> 1;
    base = S_W'(disp_i) << (FRAC_BITS - 1);
    sum  = sub_i ? (base - S_W'(half)) : (base + S_W'(half));
    if (!vis_i) begin
      res_d = '0;
    end else if (sum > SAT_HI) begin
      res_d = SAT_HI[COORD_W-1:0];
    end else if (sum < SAT_LO) begin
      res_d = SAT_LO[COORD_W-1:0];
    end else begin
      res_d = sum[COORD_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t_q   <= ndc_i * $signed({1'b0, disp_i});
      res_q <= res_d;
    end
  end

  assign coord_o = res_q;

endmodule

@@ rtl/core/perspective_point_projection.sv @@
// top level of the point projection block: config registers, valid line
// depends on ppp_pkg, ppp_dot, ppp_div, ppp_map and the defines header
//
// usage:
//   input channel: in_valid_i/in_ready_o with point_x_i, point_y_i, point_z_i
//   (signed Q16.16 world coordinates); output channel: out_valid_o/out_ready_i
//   with visible_o, screen_x_o, screen_y_o (signed Q16.16 pixels).
//   config channel: cfg_valid_i/cfg_ready_o, cfg_index_i selects the register,
//   cfg_data_i is written; indexes 8 and above are dropped. write only while idle.
//   one item per cycle sustained while the receiver takes results. the pipeline
//   holds the divider's entry stage, 40 quotient bit stages and a sign stage,
//   plus three dot product and two mapping stages.
//   the whole pipeline advances together; when the receiver holds off a
//   finished item the pipeline freezes and in_ready_o drops, nothing is lost.
//   reset clears all valid bits, zeroes the matrix and sets the display to
//   1920 by 1080; the block takes items from the first cycle after reset.
`include "perspective_point_projection_defines.svh"
module perspective_point_projection (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [ppp_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [ppp_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  ppp_pkg::coord_t                  point_x_i,
  input  ppp_pkg::coord_t                  point_y_i,
  input  ppp_pkg::coord_t                  point_z_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic                             visible_o,
  output ppp_pkg::coord_t                  screen_x_o,
  output ppp_pkg::coord_t                  screen_y_o
);
  import ppp_pkg::*;

  localparam int VIS_N = DIV_LAT + MAP_LAT;

  logic [CFG_DATA_W-1:0] row0a_q, row0b_q, row1a_q, row1b_q, row3a_q, row3b_q;
  disp_t                 width_q, height_q;
  mat_t                  mat;
  logic                  adv;
  logic [PIPE_LAT-1:0]   vld_q;
  logic [VIS_N-1:0]      vis_q;
  dot_t                  cx, cy, w;
  logic                  dot_vis;
  ndc_t                  ndc_x, ndc_y;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row0a_q  <= '0;
      row0b_q  <= '0;
      row1a_q  <= '0;
      row1b_q  <= '0;
      row3a_q  <= '0;
      row3b_q  <= '0;
      width_q  <= WIDTH_RST;
      height_q <= HEIGHT_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_ROW0_A: row0a_q  <= cfg_data_i;
        CFG_ROW0_B: row0b_q  <= cfg_data_i;
        CFG_ROW1_A: row1a_q  <= cfg_data_i;
        CFG_ROW1_B: row1b_q  <= cfg_data_i;
        CFG_ROW3_A: row3a_q  <= cfg_data_i;
        CFG_ROW3_B: row3b_q  <= cfg_data_i;
        CFG_WIDTH:  width_q  <= cfg_data_i[DISP_W-1:0];
        CFG_HEIGHT: height_q <= cfg_data_i[DISP_W-1:0];
        default: ;
      endcase
    end
  end

  assign mat.r0 = {row0a_q, row0b_q};
  assign mat.r1 = {row1a_q, row1b_q};
  assign mat.r3 = {row3a_q, row3b_q};

  assign adv         = !vld_q[PIPE_LAT-1] || out_ready_i;
  assign in_ready_o  = adv;
  assign out_valid_o = vld_q[PIPE_LAT-1];
  assign visible_o   = vis_q[VIS_N-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      vis_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[PIPE_LAT-2:0], in_valid_i};
      vis_q <= {vis_q[VIS_N-2:0], dot_vis};
    end
  end

  ppp_dot u_dot (
    .clk_i     (clk_i),
    .en_i      (adv),
    .point_x_i (point_x_i),
    .point_y_i (point_y_i),
    .point_z_i (point_z_i),
    .mat_i     (mat),
    .cx_o      (cx),
    .cy_o      (cy),
    .w_o       (w),
    .vis_o     (dot_vis)
  );

  ppp_div u_div (
    .clk_i (clk_i),
    .en_i  (adv),
    .c0_i  (cx),
    .c1_i  (cy),
    .w_i   (w),
    .q0_o  (ndc_x),
    .q1_o  (ndc_y)
  );

  ppp_map u_map_x (
    .clk_i   (clk_i),
    .en_i    (adv),
    .vis_i   (vis_q[DIV_LAT]),
    .sub_i   (1'b0),
    .disp_i  (width_q),
    .ndc_i   (ndc_x),
    .coord_o (screen_x_o)
  );

  ppp_map u_map_y (
    .clk_i   (clk_i),
    .en_i    (adv),
    .vis_i   (vis_q[DIV_LAT]),
    .sub_i   (1'b1),
    .disp_i  (height_q),
    .ndc_i   (ndc_y),
    .coord_o (screen_y_o)
  );

  `PPP_ASSERT_IMPL(a_hidden_zero, out_valid_o && !visible_o, screen_x_o == '0 && screen_y_o == '0)
  `PPP_ASSERT_NEXT(a_accept_enters, in_valid_i && in_ready_o, vld_q[0])
  `PPP_ASSERT_NEXT(a_stall_holds, !in_ready_o, $stable(vld_q) && $stable(vis_q))

endmodule
